[design/g4b_pkg.sv]
// shared types, constants and helpers for the gray4 pixel pair blender
package g4b_pkg;

	localparam int PIX_W   = 4;
	localparam int NUM_W   = 8;
	localparam int ALPHA_W = 4;
	localparam int MODE_W  = 2;

	localparam logic [PIX_W-1:0] PIX_MAX  = 4'd15;
	localparam logic [NUM_W-1:0] RND_MUL  = 8'd7;
	localparam logic [NUM_W-1:0] DIV_D    = 8'd15;
	localparam logic [4:0]       RECIP_17 = 5'd17;

	localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MULTIPLY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SCREEN   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ADD      = 2'd3;

	localparam logic REG_ALPHA      = 1'b0;
	localparam logic REG_BLEND_MODE = 1'b1;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [MODE_W-1:0]  mode;
	} cfg_t;

	// floor(num / 15) for num below 240: reciprocal estimate plus one correction
	function automatic logic [PIX_W-1:0] div15(input logic [NUM_W-1:0] num);
		logic [12:0]      prod;
		logic [PIX_W-1:0] q0;
		logic [NUM_W-1:0] back;
		logic [NUM_W-1:0] rem;
		prod = 13'(num) * 13'(RECIP_17);
		q0   = prod[11:8];
		back = 8'(q0) * DIV_D;
		rem  = num - back;
		if (rem >= DIV_D)
			div15 = q0 + 4'd1;
		else
			div15 = q0;
	endfunction

endpackage

[design/g4b_lane.sv]
// one pixel lane: blend-mode products, divide by 15, alpha mix
module g4b_lane (
	input  logic                       clk,
	input  logic                       adv,
	input  logic [g4b_pkg::PIX_W-1:0]  d,
	input  logic [g4b_pkg::PIX_W-1:0]  s,
	input  logic                       lane_on,
	input  g4b_pkg::cfg_t              cfg,
	output logic [g4b_pkg::PIX_W-1:0]  pix
);

	logic [g4b_pkg::NUM_W-1:0] num_c;
	logic [g4b_pkg::PIX_W-1:0] sum_c;
	logic [g4b_pkg::PIX_W:0]   add_c;
	logic [g4b_pkg::NUM_W-1:0] num_s2;
	logic [g4b_pkg::PIX_W-1:0] d_s2, s_s2, fast_s2;
	logic                      on_s2;

	logic [g4b_pkg::PIX_W-1:0] q_c, b_c;
	logic [g4b_pkg::PIX_W-1:0] b_s3, d_s3;
	logic                      on_s3;

	logic [g4b_pkg::NUM_W-1:0] mix_c;
	logic [g4b_pkg::PIX_W-1:0] inv_alpha;

	// stage 1 -> 2: products
	always_comb begin
		add_c = {1'b0, d} + {1'b0, s};
		sum_c = add_c[g4b_pkg::PIX_W] ? g4b_pkg::PIX_MAX : add_c[g4b_pkg::PIX_W-1:0];
		case (cfg.mode)
			g4b_pkg::MODE_MULTIPLY: num_c = 8'(d) * 8'(s) + g4b_pkg::RND_MUL;
			g4b_pkg::MODE_SCREEN:   num_c = 8'(g4b_pkg::PIX_MAX - d) * 8'(g4b_pkg::PIX_MAX - s);
			default:                num_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2  <= num_c;
			d_s2    <= d;
			s_s2    <= s;
			fast_s2 <= sum_c;
			on_s2   <= lane_on;
		end
	end

	// stage 2 -> 3: divide and select
	always_comb begin
		q_c = g4b_pkg::div15(num_s2);
		case (cfg.mode)
			g4b_pkg::MODE_MULTIPLY: b_c = q_c;
			g4b_pkg::MODE_SCREEN:   b_c = g4b_pkg::PIX_MAX - q_c;
			g4b_pkg::MODE_ADD:      b_c = fast_s2;
			default:                b_c = s_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s3  <= b_c;
			d_s3  <= d_s2;
			on_s3 <= on_s2;
		end
	end

	// stage 3 -> 4: alpha mix
	assign inv_alpha = g4b_pkg::PIX_MAX - cfg.alpha;
	assign mix_c     = 8'(b_s3) * 8'(cfg.alpha) + 8'(d_s3) * 8'(inv_alpha);

	always_ff @(posedge clk) begin
		if (adv)
			pix <= on_s3 ? mix_c[g4b_pkg::NUM_W-1:g4b_pkg::PIX_W] : d_s3;
	end

endmodule

[design/gray4_blend_pixel_pair.sv]
// top level: two-pixel 4-bit gray blender with stream ports
//
// channel   | dir | tdata (low bit up)                       | note
// s_axis    | in  | dst_byte[7:0] src_byte[15:8] lane_mask[17:16] | one word per byte
// m_axis    | out | out_byte[7:0]                             | one word per input
// cfg       | in  | alpha idx 0, blend_mode idx 1             | write only
//
// tvalid rises once the word has passed every stage below; one word per cycle sustained while m_axis is not stalled.
// stages: input register, mode products, divide by 15, alpha mix into output register.
// reset clears valid bits and sets alpha 15, blend_mode normal.
// a stall on m_axis freezes all stages together; s_axis_tready drops only then.
module gray4_blend_pixel_pair (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,  // dst_byte, src_byte, lane_mask, zero pad
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // out_byte
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [g4b_pkg::ALPHA_W-1:0]   cfg_wdata
);

	g4b_pkg::cfg_t cfg_q;
	logic          adv;
	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [7:0]    dst_s1, src_s1;
	logic [1:0]    mask_s1;
	logic [g4b_pkg::PIX_W-1:0] hi_pix, lo_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha <= g4b_pkg::PIX_MAX;
			cfg_q.mode  <= g4b_pkg::MODE_NORMAL;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				g4b_pkg::REG_ALPHA:      cfg_q.alpha <= cfg_wdata;
				g4b_pkg::REG_BLEND_MODE: cfg_q.mode  <= cfg_wdata[g4b_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv           = !vld_s4 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dst_s1  <= s_axis_tdata[7:0];
			src_s1  <= s_axis_tdata[15:8];
			mask_s1 <= s_axis_tdata[17:16];
		end
	end

	g4b_lane u_hi (
		.clk     (clk),
		.adv     (adv),
		.d       (dst_s1[7:4]),
		.s       (src_s1[7:4]),
		.lane_on (mask_s1[1]),
		.cfg     (cfg_q),
		.pix     (hi_pix)
	);

	g4b_lane u_lo (
		.clk     (clk),
		.adv     (adv),
		.d       (dst_s1[3:0]),
		.s       (src_s1[3:0]),
		.lane_on (mask_s1[0]),
		.cfg     (cfg_q),
		.pix     (lo_pix)
	);

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = {hi_pix, lo_pix};

endmodule

[tb/gray4_blend_pixel_pair_check.sv]
`timescale 1ns / 1ps
// checker for the gray4 pixel pair blender: predicts each output word and compares it
module gray4_blend_pixel_pair_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	input  logic [23:0]                  s_axis_tdata,  // dst_byte, src_byte, lane_mask, zero pad
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	input  logic [7:0]                   m_axis_tdata,  // out_byte
	input  logic                         cfg_we,
	input  logic                         cfg_addr,
	input  logic [g4b_pkg::ALPHA_W-1:0]  cfg_wdata,
	output int                           errors,
	output int                           pending,
	output int                           checked
);

	logic [g4b_pkg::ALPHA_W-1:0] alpha_cfg;
	logic [g4b_pkg::MODE_W-1:0]  mode_cfg;
	logic [7:0]                  out_byte_q[$];

	function automatic logic [g4b_pkg::PIX_W-1:0] blend_nibble(
		input logic [g4b_pkg::PIX_W-1:0]   d,
		input logic [g4b_pkg::PIX_W-1:0]   s,
		input logic [g4b_pkg::ALPHA_W-1:0] a,
		input logic [g4b_pkg::MODE_W-1:0]  mode
	);
		int unsigned dv;
		int unsigned sv;
		int unsigned av;
		int unsigned b;
		int unsigned mixed;
		dv = 32'(d);
		sv = 32'(s);
		av = 32'(a);
		case (mode)
			g4b_pkg::MODE_MULTIPLY: b = (dv * sv + 7) / 15;
			g4b_pkg::MODE_SCREEN:   b = 15 - ((15 - dv) * (15 - sv)) / 15;
			g4b_pkg::MODE_ADD: begin
				b = dv + sv;
				if (b > 15)
					b = 15;
			end
			default:                b = sv;
		endcase
		mixed = (b * av + dv * (15 - av)) >> 4;
		return mixed[g4b_pkg::PIX_W-1:0];
	endfunction

	function automatic logic [7:0] composite_byte(
		input logic [7:0]                  dst,
		input logic [7:0]                  src,
		input logic [1:0]                  lanes,
		input logic [g4b_pkg::ALPHA_W-1:0] a,
		input logic [g4b_pkg::MODE_W-1:0]  mode
	);
		logic [g4b_pkg::PIX_W-1:0] hi;
		logic [g4b_pkg::PIX_W-1:0] lo;
		hi = dst[7:4];
		lo = dst[3:0];
		if (lanes[1])
			hi = blend_nibble(dst[7:4], src[7:4], a, mode);
		if (lanes[0])
			lo = blend_nibble(dst[3:0], src[3:0], a, mode);
		return {hi, lo};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		int         err_add;
		if (!arst_n) begin
			alpha_cfg <= g4b_pkg::PIX_MAX;
			mode_cfg  <= g4b_pkg::MODE_NORMAL;
			out_byte_q.delete();
			errors    <= 0;
			pending   <= 0;
			checked   <= 0;
		end else begin
			err_add = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				if (out_byte_q.size() == 0) begin
					$error("out_byte: no word expected, got %h", m_axis_tdata);
					err_add++;
				end else begin
					want = out_byte_q.pop_front();
					if (m_axis_tdata !== want) begin
						$error("out_byte: expected %h, actual %h", want, m_axis_tdata);
						err_add++;
					end
					checked <= checked + 1;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				out_byte_q.push_back(composite_byte(s_axis_tdata[7:0], s_axis_tdata[15:8],
					s_axis_tdata[17:16], alpha_cfg, mode_cfg));
			if (cfg_we) begin
				if (cfg_addr == g4b_pkg::REG_ALPHA)
					alpha_cfg <= cfg_wdata[g4b_pkg::ALPHA_W-1:0];
				else if (cfg_addr == g4b_pkg::REG_BLEND_MODE)
					mode_cfg <= cfg_wdata[g4b_pkg::MODE_W-1:0];
			end
			errors  <= errors + err_add;
			pending <= out_byte_q.size();
		end
	end

endmodule

[tb/gray4_blend_pixel_pair_test.sv]
`timescale 1ns / 1ps
// testbench top for the gray4 pixel pair blender: stimulus, stalls and verdict
module gray4_blend_pixel_pair_test;

	localparam int IDLE_LIMIT  = 2000;
	localparam int RAND_PHASES = 16;
	localparam int PHASE_WORDS = 100;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [23:0]                  s_axis_tdata = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [7:0]                   m_axis_tdata;
	logic                         cfg_we = 1'b0;
	logic                         cfg_addr = g4b_pkg::REG_ALPHA;
	logic [g4b_pkg::ALPHA_W-1:0]  cfg_wdata = '0;

	int errors;
	int pending;
	int checked;
	int words_sent = 0;
	int settings = 1;
	int burst_left = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int rx_cycle = 0;
	bit allow_gaps = 1'b1;

	gray4_blend_pixel_pair DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	gray4_blend_pixel_pair_check checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver stall pattern, style chosen by rx_cycle bits 7:6
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case (rx_cycle[7:6])
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
			2'd2: begin
				if (stall_left > 0) begin
					m_axis_tready <= 1'b0;
					stall_left <= stall_left - 1;
				end else begin
					m_axis_tready <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						stall_left <= $urandom_range(1, 10);
				end
			end
			default: m_axis_tready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("gray4_blend_pixel_pair test failed");
				$finish;
			end
		end
	end

	function automatic logic [3:0] pick_nibble();
		case ($urandom_range(0, 5))
			0: return 4'h0;
			1: return 4'hF;
			default: return 4'($urandom_range(0, 15));
		endcase
	endfunction

	task automatic send_word(input logic [7:0] dst, input logic [7:0] src,
		input logic [1:0] lanes);
		int gap;
		if (burst_left == 0) begin
			gap = allow_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tdata  <= {6'd0, lanes, src, dst};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input logic [g4b_pkg::ALPHA_W-1:0] a,
		input logic [g4b_pkg::ALPHA_W-1:0] mode_word);
		cfg_we    <= 1'b1;
		cfg_addr  <= g4b_pkg::REG_ALPHA;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_addr  <= g4b_pkg::REG_BLEND_MODE;
		cfg_wdata <= mode_word;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	task automatic directed_words();
		send_word(8'h00, 8'hFF, 2'b11);
		send_word(8'hFF, 8'hFF, 2'b10);
		send_word(8'hF0, 8'h0F, 2'b01);
		send_word(8'h5A, 8'hC3, 2'b00);
		drain();
	endtask

	initial begin
		logic [g4b_pkg::ALPHA_W-1:0] a;
		logic [g4b_pkg::MODE_W-1:0]  mode;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings first, then each other mode at full alpha, then screen at alpha 0 and add at alpha 7
		directed_words();
		set_config(4'd15, {2'b00, g4b_pkg::MODE_MULTIPLY});
		directed_words();
		set_config(4'd15, {2'b00, g4b_pkg::MODE_SCREEN});
		directed_words();
		set_config(4'd15, {2'b00, g4b_pkg::MODE_ADD});
		directed_words();
		set_config(4'd0, {2'b11, g4b_pkg::MODE_SCREEN});
		directed_words();
		set_config(4'd7, {2'b10, g4b_pkg::MODE_ADD});
		directed_words();

		for (int p = 0; p < RAND_PHASES; p++) begin
			mode = 2'(p % 4);
			if (p < 4)
				a = 4'd0;
			else if (p < 8)
				a = 4'd15;
			else
				a = 4'($urandom_range(0, 15));
			set_config(a, {2'($urandom_range(0, 3)), mode});
			allow_gaps = (p % 3 != 0);
			for (int i = 0; i < PHASE_WORDS; i++)
				send_word({pick_nibble(), pick_nibble()}, {pick_nibble(), pick_nibble()},
					($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'b11);
			drain();
		end

		repeat (10) @(posedge clk);
		$display("covered %0d words over %0d register settings, all blend modes, alpha 0 to 15",
			words_sent, settings);
		$display("%0d output words compared, lane masks and nibble extremes included", checked);
		if (errors == 0 && pending == 0)
			$display("gray4_blend_pixel_pair test passed");
		else
			$display("gray4_blend_pixel_pair test failed");
		$finish;
	end

endmodule
